>>> hw/rtl/sacl_pkg.sv
package sacl_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_STORE  = 2'd1,
    FUNC_MODIFY = 2'd2,
    FUNC_INSTR  = 2'd3
  } sacl_func_e;

  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS  = 2'd1;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 5;

  localparam logic [2:0] SET_BITS_RST    = 3'd4;
  localparam logic [4:0] BLOCK_BITS_RST  = 5'd4;
  localparam logic [3:0] WAYS_IN_USE_RST = 4'd8;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
  } sacl_in_t;

  typedef struct packed {
    logic        hit;
    logic        miss;
    logic        evict;
    logic        last;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;
  } sacl_out_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic evict;
  } sacl_res_t;

endpackage

>>> hw/rtl/sacl_set_ram.sv
module sacl_set_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 288
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int Depth = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;
  logic [Depth-1:0]  row_ok_q;
  logic              rd_ok_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // rows never written read as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_ok_q <= '0;
      rd_ok_q  <= 1'b0;
    end else begin
      if (we_i) begin
        row_ok_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_ok_q <= row_ok_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_ok_q ? rdata_q : '0;

endmodule

>>> hw/rtl/sacl_way_logic.sv
module sacl_way_logic #(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32,
  parameter int RANK_W     = 3
) (
  input  logic [3:0]                           ways_cfg_i,
  input  logic [ADDR_WIDTH-1:0]                tag_i,
  input  logic [MAX_WAYS-1:0]                  valid_i,
  input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tag_row_i,
  input  logic [MAX_WAYS-1:0][RANK_W-1:0]      rank_i,
  output sacl_pkg::sacl_res_t                  res_o,
  output logic [MAX_WAYS-1:0]                  valid_o,
  output logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tag_row_o,
  output logic [MAX_WAYS-1:0][RANK_W-1:0]      rank_o
);

  import sacl_pkg::*;

  localparam int WayIw = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [RANK_W-1:0] MaxRank = RANK_W'(MAX_WAYS - 1);
  localparam logic [4:0] MaxWays = 5'(MAX_WAYS);

  logic [4:0]          ways_c;
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] free;
  logic [WayIw-1:0]    hit_w;
  logic [WayIw-1:0]    free_w;
  logic [WayIw-1:0]    vic_w;
  logic [WayIw-1:0]    sel_w;
  logic                hit;
  logic                has_free;
  logic                filled;
  logic [RANK_W-1:0]   old_rank;

  always_comb begin
    if (ways_cfg_i == 4'd0) begin
      ways_c = 5'd1;
    end else if ({1'b0, ways_cfg_i} > MaxWays) begin
      ways_c = MaxWays;
    end else begin
      ways_c = {1'b0, ways_cfg_i};
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      in_use[j] = 5'(j) < ways_c;
      match[j]  = in_use[j] && valid_i[j] && (tag_row_i[j] == tag_i);
      free[j]   = in_use[j] && !valid_i[j];
    end
  end

  always_comb begin
    hit_w  = '0;
    free_w = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_w = WayIw'(j);
      end
      if (free[j]) begin
        free_w = WayIw'(j);
      end
    end
  end

  // largest rank, lowest way on a tie
  always_comb begin
    vic_w = '0;
    for (int j = 1; j < MAX_WAYS; j++) begin
      if (in_use[j] && (rank_i[j] > rank_i[vic_w])) begin
        vic_w = WayIw'(j);
      end
    end
  end

  assign hit      = |match;
  assign has_free = |free;
  assign filled   = !hit;

  always_comb begin
    priority if (hit) begin
      sel_w = hit_w;
    end else if (has_free) begin
      sel_w = free_w;
    end else begin
      sel_w = vic_w;
    end
  end

  assign old_rank = rank_i[sel_w];

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      valid_o[j]   = valid_i[j];
      tag_row_o[j] = tag_row_i[j];
      rank_o[j]    = rank_i[j];
      if (WayIw'(j) == sel_w) begin
        rank_o[j] = '0;
        if (filled) begin
          valid_o[j]   = 1'b1;
          tag_row_o[j] = tag_i;
        end
      end else if (in_use[j] && valid_i[j] && (filled || (rank_i[j] < old_rank)) &&
                   (rank_i[j] != MaxRank)) begin
        rank_o[j] = rank_i[j] + 1'b1;
      end
    end
  end

  assign res_o.hit   = hit;
  assign res_o.miss  = !hit;
  assign res_o.evict = !hit && !has_free;

endmodule

>>> hw/rtl/set_assoc_cache_lru_lookup.sv
// Set-associative tag store with true LRU replacement. Each input beat is one access
// (load, store, modify, instruction); the set row (valid, tag and LRU rank of every way)
// sits in one synchronous memory and is read, updated and written back per lookup.
// A load or store is accepted and then looked up on the registered memory read, a modify
// does a second lookup on the forwarded row, and an instruction access is accepted with
// no result and no lookup; an output stall holds the beat in the lookup state. One beat
// is in flight at a time, but the next beat is taken while a result waits in the output
// register. Rows carry a valid flip-flop each, so no clearing pass follows reset.
module set_assoc_cache_lru_lookup #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sacl_pkg::sacl_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sacl_pkg::sacl_out_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sacl_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [sacl_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  import sacl_pkg::*;

  localparam int SetIw  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RankW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RowW   = MAX_WAYS * (1 + ADDR_WIDTH + RankW);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic [2:0] set_bits_q;
  logic [4:0] block_bits_q;
  logic [3:0] ways_q;

  logic                  state_q, state_d;
  logic                  pass_q, pass_d;
  logic                  modify_q;
  logic [SetIw-1:0]      set_q;
  logic [ADDR_WIDTH-1:0] tag_q;

  logic [2:0]            s_c;
  logic [5:0]            sh;
  logic [ADDR_WIDTH-1:0] addr_c;
  logic [ADDR_WIDTH-1:0] set_full;
  logic [SetIw-1:0]      set_c;
  logic [ADDR_WIDTH-1:0] tag_c;

  logic                  accept;
  logic                  start;
  logic                  out_free;
  logic                  go;
  logic                  last;

  logic [RowW-1:0]                      rd_row;
  logic [RowW-1:0]                      cur_row;
  logic [RowW-1:0]                      new_row;
  logic [RowW-1:0]                      fwd_q;
  logic [MAX_WAYS-1:0]                  cur_valid;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  cur_tag;
  logic [MAX_WAYS-1:0][RankW-1:0]       cur_rank;
  logic [MAX_WAYS-1:0]                  new_valid;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  new_tag;
  logic [MAX_WAYS-1:0][RankW-1:0]       new_rank;
  sacl_res_t                            res;

  logic [31:0] hit_cnt_q, hit_cnt_d;
  logic [31:0] miss_cnt_q, miss_cnt_d;
  logic [31:0] evict_cnt_q, evict_cnt_d;
  logic        out_valid_q;
  sacl_out_t   out_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= SET_BITS_RST;
      block_bits_q <= BLOCK_BITS_RST;
      ways_q       <= WAYS_IN_USE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SET_BITS:    set_bits_q   <= cfg_data_i[2:0];
        CFG_BLOCK_BITS:  block_bits_q <= cfg_data_i;
        CFG_WAYS_IN_USE: ways_q       <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // address split
  always_comb begin
    s_c      = (int'(set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;
    sh       = 6'(s_c) + 6'(block_bits_q);
    addr_c   = ADDR_WIDTH'(in_data_i.address);
    tag_c    = addr_c >> sh;
    set_full = addr_c >> block_bits_q;
    for (int i = 0; i < SetIw; i++) begin
      set_c[i] = set_full[i] && (i < int'(s_c));
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign start      = accept && (in_data_i.func != FUNC_INSTR);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign go         = (state_q == ST_LOOK) && out_free;
  assign last       = !modify_q || pass_q;

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        pass_d = 1'b0;
        if (start) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (go) begin
          if (last) begin
            state_d = ST_IDLE;
            pass_d  = 1'b0;
          end else begin
            pass_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      set_q    <= set_c;
      tag_q    <= tag_c;
      modify_q <= (in_data_i.func == FUNC_MODIFY);
    end
    if (go) begin
      fwd_q <= new_row;
    end
  end

  sacl_set_ram #(
    .ADDR_W(SetIw),
    .DATA_W(RowW)
  ) u_set_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (go),
    .waddr_i(set_q),
    .wdata_i(new_row),
    .re_i   (start),
    .raddr_i(set_c),
    .rdata_o(rd_row)
  );

  // second lookup of a modify sees the row just written
  assign cur_row = pass_q ? fwd_q : rd_row;
  assign {cur_valid, cur_tag, cur_rank} = cur_row;
  assign new_row = {new_valid, new_tag, new_rank};

  sacl_way_logic #(
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH),
    .RANK_W    (RankW)
  ) u_way_logic (
    .ways_cfg_i(ways_q),
    .tag_i     (tag_q),
    .valid_i   (cur_valid),
    .tag_row_i (cur_tag),
    .rank_i    (cur_rank),
    .res_o     (res),
    .valid_o   (new_valid),
    .tag_row_o (new_tag),
    .rank_o    (new_rank)
  );

  assign hit_cnt_d   = hit_cnt_q + 32'(res.hit);
  assign miss_cnt_d  = miss_cnt_q + 32'(res.miss);
  assign evict_cnt_d = evict_cnt_q + 32'(res.evict);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (go) begin
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        evict_cnt_q <= evict_cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_q.hit         <= res.hit;
      out_q.miss        <= res.miss;
      out_q.evict       <= res.evict;
      out_q.last        <= last;
      out_q.hit_total   <= hit_cnt_d;
      out_q.miss_total  <= miss_cnt_d;
      out_q.evict_total <= evict_cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_second_pass_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && pass_q) |-> res.hit)
    else $error("second lookup of a modify missed");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.hit != out_data_o.miss) &&
                     !(out_data_o.evict && out_data_o.hit)))
    else $error("inconsistent result beat");

  a_start_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == ST_LOOK) && !pass_q)
    else $error("accepted beat did not enter lookup");
`endif

endmodule
